[rtl/core/prf_pkg.sv]
// prf_pkg: shared constants, types, command codes and states of the
// push-relabel max flow block; no dependencies
package prf_pkg;

   localparam int MAX_NODES = 32;
   localparam int CAP_BITS  = 32;

   localparam int NODE_BITS  = $clog2(MAX_NODES);
   localparam int CNT_BITS   = NODE_BITS + 1;
   localparam int ADDR_BITS  = 2 * NODE_BITS;
   localparam int MEM_DEPTH  = MAX_NODES * MAX_NODES;
   localparam int FLOW_BITS  = CAP_BITS + 2;
   localparam int ROOM_BITS  = CAP_BITS + 3;
   localparam int EXC_BITS   = CAP_BITS + NODE_BITS + 3;
   localparam int HT_BITS    = 8;
   localparam int NC_BITS    = 6;
   localparam int CMD_BITS   = 2;
   localparam int DELTA_BITS = 32;
   localparam int OUT_BITS   = 37;
   localparam int SUM_BITS   = ((CAP_BITS > DELTA_BITS) ? CAP_BITS : DELTA_BITS) + 2;

   typedef logic [NODE_BITS-1:0]        node_type;
   typedef logic [CNT_BITS-1:0]         count_type;
   typedef logic [ADDR_BITS-1:0]        addr_type;
   typedef logic [CAP_BITS-1:0]         cap_type;
   typedef logic signed [FLOW_BITS-1:0] flow_type;
   typedef logic signed [ROOM_BITS-1:0] room_type;
   typedef logic signed [EXC_BITS-1:0]  exc_type;
   typedef logic [HT_BITS-1:0]          ht_type;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD     = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_COMPUTE = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLR, ST_IDLE, ST_ADD_WR, ST_FCLR, ST_SRC_RD, ST_SRC_EV, ST_SRC_MIR,
      ST_QCHK, ST_POP, ST_RD, ST_ROOM, ST_AMT, ST_PUSH, ST_MIR, ST_NODE_END,
      ST_DONE
   } state_type;

   // control of the active node queue
   typedef struct packed {
      logic     flush;
      logic     push;
      logic     pop;
      node_type node;
   } q_ctrl_type;

endpackage

[rtl/core/prf_req_if.sv]
// prf_req_if: request channel of the max flow block, valid/ready handshake
// depends on prf_pkg for field widths
interface prf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [prf_pkg::CMD_BITS-1:0]         command;
   logic [prf_pkg::NC_BITS-1:0]          from_node;
   logic [prf_pkg::NC_BITS-1:0]          to_node;
   logic signed [prf_pkg::DELTA_BITS-1:0] delta;

   modport source (output valid, command, from_node, to_node, delta, input ready);
   modport sink   (input valid, command, from_node, to_node, delta, output ready);
endinterface

[rtl/core/prf_rsp_if.sv]
// prf_rsp_if: response channel of the max flow block, valid/ready handshake
// depends on prf_pkg for field widths
interface prf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [prf_pkg::OUT_BITS-1:0] max_flow;

   modport source (output valid, max_flow, input ready);
   modport sink   (input valid, max_flow, output ready);
endinterface

[rtl/core/prf_queue.sv]
// prf_queue: circular queue of active nodes with head index and fill count
// depends on prf_pkg
module prf_queue (
   input  logic                clock,
   input  logic                reset,
   input  prf_pkg::q_ctrl_type ctrl,
   output prf_pkg::node_type   head,
   output prf_pkg::count_type  count
);
   import prf_pkg::*;

   node_type  slot_ff [MAX_NODES];
   node_type  head_ff;
   node_type  head_in;
   count_type count_ff;
   count_type count_in;
   logic      put_ok;
   node_type  tail;
   logic [CNT_BITS:0] tail_sum;

   assign put_ok   = ctrl.push && (int'(count_ff) < MAX_NODES);
   assign tail_sum = (CNT_BITS+1)'(head_ff) + (CNT_BITS+1)'(count_ff);
   assign tail     = (int'(tail_sum) >= MAX_NODES)
                     ? NODE_BITS'(int'(tail_sum) - MAX_NODES)
                     : NODE_BITS'(tail_sum);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.flush) begin
         head_in  = '0;
         count_in = '0;
      end else begin
         if (ctrl.pop) begin
            head_in = (int'(head_ff) == MAX_NODES - 1) ? '0 : head_ff + 1'b1;
         end
         count_in = count_ff + count_type'(put_ok) - count_type'(ctrl.pop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put_ok && !ctrl.flush) begin
         slot_ff[tail] <= ctrl.node;
      end
   end

   assign head  = slot_ff[head_ff];
   assign count = count_ff;

endmodule

[rtl/core/push_relabel_max_flow_top.sv]
// push_relabel_max_flow_top: fifo push-relabel max flow over a dense graph
// add reads the capacity entry, then writes it back; clear sweeps the capacity ram;
//   compute clears the flow ram, scans the source row, then discharges each popped
//   node over its columns and pushes where it can; the response leaves the done state once the output register is free
// throughput: one item at a time, as a request is taken only in the idle state
// reset: synchronous, then a sweep zeroes the whole capacity ram, no
//   request transfer is taken until it ends; node_count resets to 2
module push_relabel_max_flow_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [prf_pkg::NC_BITS-1:0] csr_wdata,
   prf_req_if.sink                     req_ch,
   prf_rsp_if.source                   rsp_ch
);
   import prf_pkg::*;

   // ---------------------------------------------------------------- storage
   // capacity and flow matrices, row = tail node, column = head node
   cap_type  cap_mem  [MEM_DEPTH];
   flow_type flow_mem [MEM_DEPTH];

   // per-node state in flops, one read address each
   exc_type  excess_ff [MAX_NODES];
   ht_type   height_ff [MAX_NODES];
   logic [MAX_NODES-1:0] nq_ff;   // node not queued

   // ---------------------------------------------------------------- control
   state_type state_ff, state_in;
   logic [NC_BITS-1:0] n_cfg_ff;
   count_type n_ff;
   count_type n_start;
   node_type  sink_node;
   node_type  sink_start;
   logic [MAX_NODES-1:0] nq_start;
   addr_type  sweep_ff;
   node_type  idx_ff;      // source scan index or push target
   node_type  x_ff;        // node being discharged
   ht_type    hx_ff;
   exc_type   ex_x_ff;
   exc_type   sink_ff;     // running sink excess
   cap_type   cap_rdata_ff;
   flow_type  flow_rdata_ff;
   flow_type  flow_ff;
   flow_type  mirror_ff;
   room_type  room_ff;
   logic      elig_ff;
   exc_type   amt_ff;
   addr_type  addr_ff;
   logic signed [DELTA_BITS-1:0] delta_ff;
   logic      rsp_valid_ff;
   logic [OUT_BITS-1:0] rsp_data_ff;

   // memory ports
   logic     cap_we;
   addr_type cap_waddr, cap_raddr;
   cap_type  cap_wdata;
   logic     flow_we;
   addr_type flow_waddr, flow_raddr;
   flow_type flow_wdata;

   q_ctrl_type q_ctrl;
   node_type   q_head;
   count_type  q_count;

   logic req_xfer;
   logic add_ok;
   addr_type add_addr;
   node_type rd_node;
   logic src_hit;
   logic push_cond;
   logic rsp_free;
   flow_type new_flow;
   exc_type  room_ext;
   logic signed [SUM_BITS-1:0] add_sum;
   cap_type  sat_cap;

   prf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctrl  (q_ctrl),
      .head  (q_head),
      .count (q_count)
   );

   // ------------------------------------------------------- request decode
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign add_ok = (req_ch.from_node != '0) && (req_ch.to_node != '0)
                   && (int'(req_ch.from_node) <= MAX_NODES)
                   && (int'(req_ch.to_node) <= MAX_NODES);
   assign add_addr = {NODE_BITS'(req_ch.from_node - 1'b1),
                      NODE_BITS'(req_ch.to_node - 1'b1)};

   // node count clamped into range when a compute starts
   always_comb begin
      if (int'(n_cfg_ff) < 2) begin
         n_start = count_type'(2);
      end else if (int'(n_cfg_ff) > MAX_NODES) begin
         n_start = count_type'(MAX_NODES);
      end else begin
         n_start = count_type'(n_cfg_ff);
      end
   end

   // source and sink start out of the queue
   assign sink_start = NODE_BITS'(n_start - 1'b1);
   assign nq_start   = ~(MAX_NODES'(1) | (MAX_NODES'(1) << sink_start));

   assign sink_node = NODE_BITS'(n_ff - 1'b1);
   assign rd_node   = (state_ff == ST_POP) ? q_head : idx_ff;
   assign src_hit   = (cap_rdata_ff != '0);
   assign push_cond = elig_ff && !room_ff[ROOM_BITS-1] && (room_ff != '0);
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign room_ext  = EXC_BITS'(room_ff);
   assign new_flow  = flow_ff + FLOW_BITS'(amt_ff);

   // saturating capacity update
   always_comb begin
      add_sum = SUM_BITS'($signed({1'b0, cap_rdata_ff})) + SUM_BITS'(delta_ff);
      if (add_sum[SUM_BITS-1]) begin
         sat_cap = '0;
      end else if (|add_sum[SUM_BITS-2:CAP_BITS]) begin
         sat_cap = '1;
      end else begin
         sat_cap = add_sum[CAP_BITS-1:0];
      end
   end

   // ----------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLR:      if (&sweep_ff) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_ch.command)
                  CMD_ADD:     if (add_ok) state_in = ST_ADD_WR;
                  CMD_CLEAR:   state_in = ST_CLR;
                  CMD_COMPUTE: state_in = ST_FCLR;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_WR:   state_in = ST_IDLE;
         ST_FCLR:     if (&sweep_ff) state_in = ST_SRC_RD;
         ST_SRC_RD:   state_in = ST_SRC_EV;
         ST_SRC_EV: begin
            if (src_hit) begin
               state_in = ST_SRC_MIR;
            end else begin
               state_in = (idx_ff == sink_node) ? ST_QCHK : ST_SRC_RD;
            end
         end
         ST_SRC_MIR:  state_in = (idx_ff == sink_node) ? ST_QCHK : ST_SRC_RD;
         ST_QCHK:     state_in = (q_count != '0) ? ST_POP : ST_DONE;
         ST_POP:      state_in = ST_RD;
         ST_RD:       state_in = ST_ROOM;
         ST_ROOM:     state_in = ST_AMT;
         ST_AMT: begin
            if (push_cond) begin
               state_in = ST_PUSH;
            end else begin
               state_in = (idx_ff == '0) ? ST_NODE_END : ST_RD;
            end
         end
         ST_PUSH:     state_in = ST_MIR;
         ST_MIR:      state_in = (idx_ff == '0) ? ST_NODE_END : ST_RD;
         ST_NODE_END: state_in = ST_QCHK;
         ST_DONE:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------ memory and queue
   always_comb begin
      cap_we     = 1'b0;
      cap_waddr  = sweep_ff;
      cap_wdata  = '0;
      cap_raddr  = '0;
      flow_we    = 1'b0;
      flow_waddr = sweep_ff;
      flow_wdata = '0;
      flow_raddr = '0;
      q_ctrl     = '0;
      case (state_ff)
         ST_CLR: cap_we = 1'b1;
         ST_IDLE: begin
            cap_raddr    = add_addr;
            q_ctrl.flush = req_xfer && (req_ch.command == CMD_COMPUTE);
         end
         ST_ADD_WR: begin
            cap_we    = 1'b1;
            cap_waddr = addr_ff;
            cap_wdata = sat_cap;
         end
         ST_FCLR: flow_we = 1'b1;
         ST_SRC_RD: cap_raddr = {NODE_BITS'(0), idx_ff};
         ST_SRC_EV: begin
            flow_we     = src_hit;
            flow_waddr  = {NODE_BITS'(0), idx_ff};
            flow_wdata  = FLOW_BITS'($signed({1'b0, cap_rdata_ff}));
            q_ctrl.push = src_hit && (idx_ff != sink_node);
            q_ctrl.node = idx_ff;
         end
         ST_SRC_MIR: begin
            flow_we    = 1'b1;
            flow_waddr = {idx_ff, NODE_BITS'(0)};
            flow_wdata = mirror_ff;
         end
         ST_POP: q_ctrl.pop = 1'b1;
         ST_RD: begin
            cap_raddr  = {x_ff, idx_ff};
            flow_raddr = {x_ff, idx_ff};
         end
         ST_PUSH: begin
            flow_we     = 1'b1;
            flow_waddr  = {x_ff, idx_ff};
            flow_wdata  = new_flow;
            q_ctrl.push = nq_ff[idx_ff];
            q_ctrl.node = idx_ff;
         end
         ST_MIR: begin
            flow_we    = 1'b1;
            flow_waddr = {idx_ff, x_ff};
            flow_wdata = mirror_ff;
         end
         ST_NODE_END: begin
            q_ctrl.push = (ex_x_ff != '0);
            q_ctrl.node = x_ff;
         end
         default: q_ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_mem[cap_waddr] <= cap_wdata;
      end
      cap_rdata_ff <= cap_mem[cap_raddr];
   end

   always_ff @(posedge clock) begin
      if (flow_we) begin
         flow_mem[flow_waddr] <= flow_wdata;
      end
      flow_rdata_ff <= flow_mem[flow_raddr];
   end

   // ---------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         sweep_ff     <= '0;
         n_cfg_ff     <= NC_BITS'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            n_cfg_ff <= csr_wdata;
         end
         // sweep counter restarts on entry to a clearing pass
         if (state_ff == ST_CLR || state_ff == ST_FCLR) begin
            sweep_ff <= sweep_ff + 1'b1;
         end else begin
            sweep_ff <= '0;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------ datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            addr_ff  <= add_addr;
            delta_ff <= req_ch.delta;
            if (req_xfer && req_ch.command == CMD_COMPUTE) begin
               n_ff    <= n_start;
               sink_ff <= '0;
               idx_ff  <= NODE_BITS'(1);
            end
         end
         ST_SRC_EV: begin
            mirror_ff <= -FLOW_BITS'($signed({1'b0, cap_rdata_ff}));
            if (src_hit && idx_ff == sink_node) begin
               sink_ff <= EXC_BITS'($signed({1'b0, cap_rdata_ff}));
            end
            if (!src_hit && idx_ff != sink_node) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         ST_SRC_MIR: begin
            if (idx_ff != sink_node) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         ST_POP: begin
            x_ff    <= q_head;
            ex_x_ff <= excess_ff[rd_node];
            hx_ff   <= height_ff[rd_node];
            idx_ff  <= sink_node;
         end
         ST_ROOM: begin
            flow_ff <= flow_rdata_ff;
            room_ff <= ROOM_BITS'($signed({1'b0, cap_rdata_ff}))
                       - ROOM_BITS'(flow_rdata_ff);
            elig_ff <= (HT_BITS'(height_ff[rd_node] + 1'b1) == hx_ff);
         end
         ST_AMT: begin
            // push amount is the smaller of excess and residual room
            amt_ff <= (ex_x_ff < room_ext) ? ex_x_ff : room_ext;
            if (!push_cond && idx_ff != '0) begin
               idx_ff <= idx_ff - 1'b1;
            end
         end
         ST_PUSH: begin
            mirror_ff <= -new_flow;
            ex_x_ff   <= ex_x_ff - amt_ff;
            if (idx_ff == sink_node) begin
               sink_ff <= sink_ff + amt_ff;
            end
         end
         ST_MIR: begin
            if (idx_ff != '0) begin
               idx_ff <= idx_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_data_ff <= OUT_BITS'($unsigned(sink_ff));
            end
         end
         default: begin
         end
      endcase
   end

   // per-node excess, height and queued flags
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_ch.command == CMD_COMPUTE) begin
               for (int i = 0; i < MAX_NODES; i++) begin
                  excess_ff[i] <= '0;
                  height_ff[i] <= (i == 0) ? HT_BITS'(n_start) : '0;
               end
               nq_ff <= nq_start;
            end
         end
         ST_SRC_EV: begin
            if (src_hit) begin
               excess_ff[idx_ff] <= EXC_BITS'($signed({1'b0, cap_rdata_ff}));
               nq_ff[idx_ff]     <= 1'b0;
            end
         end
         ST_PUSH: begin
            excess_ff[rd_node] <= excess_ff[rd_node] + amt_ff;
            nq_ff[idx_ff]      <= 1'b0;
         end
         ST_NODE_END: begin
            excess_ff[x_ff] <= ex_x_ff;
            if (ex_x_ff != '0) begin
               height_ff[x_ff] <= hx_ff + 1'b1;   // relabel by one
            end else begin
               nq_ff[x_ff] <= 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.max_flow = rsp_data_ff;

   // ------------------------------------------------------------ assertions
   // the sink is never discharged
   a_no_sink_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |-> (x_ff != sink_node))
      else $error("sink node taken from active queue");

   // every mirror write follows the forward flow write
   a_mirror_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIR || state_ff == ST_SRC_MIR)
      |-> $past(flow_we) && ($past(state_ff) == ST_PUSH || $past(state_ff) == ST_SRC_EV))
      else $error("mirror flow write without forward write");

   // a response only rises out of the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside of done state");

endmodule
